// ----- sv/hotp_pkg.sv -----
package hotp_pkg;
   localparam int KeyBytesMax = 24;
   localparam logic [4:0] KeyLenReset = 5'd20;
   localparam logic [3:0] DigitsReset = 4'd6;
   localparam logic [3:0] DigitsMax = 4'd10;
   localparam logic [2:0] CsrKeyHigh = 3'd0;
   localparam logic [2:0] CsrKeyMid = 3'd1;
   localparam logic [2:0] CsrKeyLow = 3'd2;
   localparam logic [2:0] CsrKeyLength = 3'd3;
   localparam logic [2:0] CsrDigitCount = 3'd4;
   localparam logic [159:0] Sha1Init =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

   typedef struct packed {
      logic start;
      logic init;
      logic [511:0] block;
   } sha_cmd_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] pow10(input logic [3:0] nd);
      case (nd)
         4'd1: pow10 = 32'd10;
         4'd2: pow10 = 32'd100;
         4'd3: pow10 = 32'd1000;
         4'd4: pow10 = 32'd10000;
         4'd5: pow10 = 32'd100000;
         4'd6: pow10 = 32'd1000000;
         4'd7: pow10 = 32'd10000000;
         4'd8: pow10 = 32'd100000000;
         default: pow10 = 32'd1000000000;
      endcase
   endfunction
endpackage

// ----- sv/hotp_sha1_core.sv -----
module hotp_sha1_core
   import hotp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sha_cmd_type  cmd,
   output logic         done,
   output logic [159:0] digest
);
   logic [31:0] w_ff [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [159:0] h_ff;
   logic [6:0] round_ff;
   logic busy_ff, done_ff;
   logic [31:0] f, k, t, wi, wnew;
   logic [159:0] hsel;

   assign hsel = cmd.init ? Sha1Init : h_ff;
   assign wnew = rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);
   assign wi = (round_ff < 7'd16) ? w_ff[round_ff[3:0]] : wnew;

   always_comb begin
      if (round_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = 32'h5A827999;
      end else if (round_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'h6ED9EBA1;
      end else if (round_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = 32'h8F1BBCDC;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'hCA62C1D6;
      end
      t = rotl(a_ff, 5) + f + e_ff + k + wi;
   end

   always_ff @(posedge clock) begin
      done_ff <= !reset && !cmd.start && busy_ff && (round_ff == 7'd79);
      if (reset) begin
         busy_ff <= 1'b0;
         round_ff <= '0;
      end else if (cmd.start) begin
         busy_ff <= 1'b1;
         round_ff <= '0;
         h_ff <= hsel;
         {a_ff, b_ff, c_ff, d_ff, e_ff} <= hsel;
         for (int i = 0; i < 16; i++) w_ff[i] <= cmd.block[511 - 32 * i -: 32];
      end else if (busy_ff) begin
         {a_ff, b_ff, c_ff, d_ff, e_ff} <= {t, a_ff, rotl(b_ff, 30), c_ff, d_ff};
         if (round_ff >= 7'd16) begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
            w_ff[15] <= wnew;
         end
         if (round_ff == 7'd79) begin
            busy_ff <= 1'b0;
            h_ff <= {h_ff[159:128] + t, h_ff[127:96] + a_ff,
                     h_ff[95:64] + rotl(b_ff, 30), h_ff[63:32] + c_ff,
                     h_ff[31:0] + d_ff};
         end
         round_ff <= round_ff + 7'd1;
      end
   end

   assign done = done_ff;
   assign digest = h_ff;
endmodule

// ----- sv/hotp_code_generator_top.sv -----
// HOTP code generator (HMAC-SHA1 with dynamic truncation).
// Request channel: req_valid/req_stall with req_counter (64 bits). Result
// channel: rsp_valid/rsp_stall with rsp_decimal_code and rsp_hex_code.
// A transaction moves when valid is high and stall is low.
// Configuration: csr_valid/csr_ready, csr_index and csr_data; ready is high
// while no request is in flight. Indexes 0..2 key words, 3 key length,
// 4 digit count; other indexes are ignored.
// One shared SHA-1 round unit does four 80-round compressions in turn, then
// truncation and setup, then a modulo by repeated subtraction of shifted
// powers of ten (skipped with 10 digits).
// One request is in flight at a time; req_stall is high from acceptance
// until the result is taken, and the next request can be taken in the cycle
// after that.
// A stalled result holds its value until rsp_stall drops.
// Reset (synchronous, active high) clears the key, sets key length 20 and
// digit count 6, and drops all pending work.
module hotp_code_generator_top
   import hotp_pkg::*;
#(
   parameter int MAX_KEY_BYTES = KeyBytesMax
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_counter,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_decimal_code,
   output logic [30:0] rsp_hex_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   typedef enum logic [2:0] {IDLE, B0, B1, B2, B3, MODW, MOD, OUT} state_type;
   state_type state_ff;
   logic [63:0] kh_ff, km_ff, kl_ff, ctr_ff;
   logic [4:0] klen_ff;
   logic [3:0] nd_ff;
   logic [159:0] inner_ff;
   logic [30:0] val_ff, hex_ff;
   logic [31:0] p_ff;
   logic [5:0] sh_ff;
   logic [191:0] key_bits;
   logic [511:0] k0;
   sha_cmd_type cmd;
   logic done, start;
   logic [159:0] digest;
   logic [3:0] off;
   logic [31:0] sel;
   logic [62:0] sub;
   logic [3:0] nd_eff;

   hotp_sha1_core u_core(.clock, .reset, .cmd, .done, .digest);

   always_comb begin
      key_bits = {kh_ff, km_ff, kl_ff};
      for (int i = 0; i < 24; i++)
         if (i >= int'(klen_ff)) key_bits[191 - 8 * i -: 8] = 8'h00;
      k0 = {key_bits, 320'd0};
   end

   assign start = (state_ff == IDLE && req_valid) || (done &&
                  (state_ff == B0 || state_ff == B1 || state_ff == B2));
   always_comb begin
      cmd.start = start;
      cmd.init = (state_ff == IDLE) || (state_ff == B1);
      case (state_ff)
         IDLE: cmd.block = k0 ^ {64{8'h36}};
         B0: cmd.block = {ctr_ff, 8'h80, 376'd0, 64'd576};
         B1: cmd.block = k0 ^ {64{8'h5C}};
         default: cmd.block = {inner_ff, 8'h80, 280'd0, 64'd672};
      endcase
   end

   assign off = digest[3:0];
   assign sel = digest[159 - 8 * off -: 32];
   assign sub = {32'd0, val_ff} - ({31'd0, p_ff} << sh_ff);
   assign nd_eff = (nd_ff == 4'd0) ? 4'd1 : nd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         kh_ff <= '0; km_ff <= '0; kl_ff <= '0;
         klen_ff <= KeyLenReset;
         nd_ff <= DigitsReset;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrKeyHigh: kh_ff <= csr_data;
               CsrKeyMid: km_ff <= csr_data;
               CsrKeyLow: kl_ff <= csr_data;
               CsrKeyLength: klen_ff <= (csr_data[4:0] > 5'(MAX_KEY_BYTES)) ?
                                        5'(MAX_KEY_BYTES) : csr_data[4:0];
               CsrDigitCount: nd_ff <= (csr_data[3:0] > DigitsMax) ?
                                       DigitsMax : csr_data[3:0];
               default: ;
            endcase
         end
         case (state_ff)
            IDLE: if (req_valid) begin
               ctr_ff <= req_counter;
               state_ff <= B0;
            end
            B0: if (done) state_ff <= B1;
            B1: if (done) begin
               inner_ff <= digest;
               state_ff <= B2;
            end
            B2: if (done) state_ff <= B3;
            B3: if (done) begin
               val_ff <= sel[30:0];
               state_ff <= MODW;
            end
            MODW: begin
               hex_ff <= (nd_eff >= 4'd8) ? val_ff : val_ff &
                         ((31'd1 << {nd_eff[2:0], 2'b00}) - 31'd1);
               p_ff <= pow10(nd_eff);
               sh_ff <= 6'd31;
               state_ff <= (nd_eff >= DigitsMax) ? OUT : MOD;
            end
            MOD: begin
               if (!sub[62]) val_ff <= sub[30:0];
               sh_ff <= sh_ff - 6'd1;
               if (sh_ff == 6'd0) state_ff <= OUT;
            end
            OUT: if (!rsp_stall) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign csr_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == OUT);
   assign rsp_decimal_code = val_ff;
   assign rsp_hex_code = hex_ff;
endmodule
